// ===== rtl/fqd_pkg.sv =====
package fqd_pkg;

  localparam int unsigned DEPTH_DEF      = 32;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // port widths of the result fields
  localparam int unsigned OUT_W = 32;
  localparam int unsigned LEN_W = 6;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [1:0] {
    KIND_ENQ  = 2'd0,
    KIND_DEQ  = 2'd1,
    KIND_DEL  = 2'd2,
    KIND_ITER = 2'd3
  } fqd_kind_e;

  // controller -> datapath
  typedef struct packed {
    logic load_cmd;   // capture the command, clear the walk index
    logic rd;         // read entry at offset idx_d (+1 with rd_skip)
    logic rd_skip;
    logic idx_inc;
    logic enq;
    logic deq;
    logic shift_wr;   // move the read entry down one place
    logic del;
    logic emit;       // load the output register
    logic emit_rej;
    logic emit_data;
    logic emit_last;
  } fqd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    fqd_kind_e kind;
    logic      val_zero;
    logic      empty;
    logic      full;
    logic      hit;
    logic      at_last;
    logic      out_free;
  } fqd_sts_t;

endpackage

// ===== rtl/fqd_ram.sv =====
module fqd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fqd_ctrl.sv =====
module fqd_ctrl import fqd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fqd_sts_t sts_i,
  output fqd_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_SHIFT = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_cmd = 1'b1;
          cmd_o.rd       = 1'b1;   // fetch the head entry
          state_d        = S_RUN;
        end
      end
      S_RUN: begin
        case (sts_i.kind)
          KIND_ENQ: begin
            if (sts_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              cmd_o.emit_rej  = sts_i.val_zero | sts_i.full;
              cmd_o.enq       = ~(sts_i.val_zero | sts_i.full);
              state_d         = S_IDLE;
            end
          end
          KIND_DEQ: begin
            if (sts_i.out_free) begin
              cmd_o.emit      = 1'b1;
              cmd_o.emit_last = 1'b1;
              cmd_o.emit_rej  = sts_i.empty;
              cmd_o.emit_data = ~sts_i.empty;
              cmd_o.deq       = ~sts_i.empty;
              state_d         = S_IDLE;
            end
          end
          KIND_ITER: begin
            if (sts_i.out_free) begin
              cmd_o.emit = 1'b1;
              if (sts_i.empty) begin
                cmd_o.emit_last = 1'b1;
                state_d         = S_IDLE;
              end else begin
                cmd_o.emit_data = 1'b1;
                cmd_o.emit_last = sts_i.at_last;
                if (sts_i.at_last) begin
                  state_d = S_IDLE;
                end else begin
                  cmd_o.idx_inc = 1'b1;
                  cmd_o.rd      = 1'b1;
                end
              end
            end
          end
          KIND_DEL: begin
            if (sts_i.val_zero || sts_i.empty) begin
              if (sts_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_last = 1'b1;
                cmd_o.emit_rej  = 1'b1;
                state_d         = S_IDLE;
              end
            end else if (sts_i.hit) begin
              cmd_o.rd      = 1'b1;
              cmd_o.rd_skip = 1'b1;
              state_d       = S_SHIFT;
            end else if (sts_i.at_last) begin
              if (sts_i.out_free) begin
                cmd_o.emit      = 1'b1;
                cmd_o.emit_last = 1'b1;
                cmd_o.emit_rej  = 1'b1;
                state_d         = S_IDLE;
              end
            end else begin
              cmd_o.idx_inc = 1'b1;
              cmd_o.rd      = 1'b1;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_SHIFT: begin
        if (sts_i.at_last) begin
          if (sts_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            cmd_o.del       = 1'b1;
            state_d         = S_IDLE;
          end
        end else begin
          cmd_o.shift_wr = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          cmd_o.rd       = 1'b1;
          cmd_o.rd_skip  = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/fqd_datapath.sv =====
module fqd_datapath import fqd_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [1:0]       kind_i,
  input  logic [OUT_W-1:0] item_value_i,
  input  fqd_cmd_t         cmd_i,
  output fqd_sts_t         sts_o,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic             status_o,
  output logic [OUT_W-1:0] out_value_o,
  output logic [LEN_W-1:0] length_now_o,
  output logic             last_o
);

  localparam int unsigned AW  = $clog2(DEPTH);
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned SW  = CW + 1;
  localparam int unsigned XW  = VALUE_BITS + OUT_W;
  localparam int unsigned LXW = CW + LEN_W;

  // physical slot of an offset from the head
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         rd_off;
  fqd_kind_e             kind_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [XW-1:0]         in_ext;
  logic [XW-1:0]         out_ext;
  logic [LXW-1:0]        len_ext;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [AW-1:0]         raddr;
  logic [VALUE_BITS-1:0] wdata;
  logic [VALUE_BITS-1:0] rdata;

  logic                  ovalid_q;
  logic                  ostatus_q;
  logic [OUT_W-1:0]      ovalue_q;
  logic [LEN_W-1:0]      olen_q;
  logic                  olast_q;

  assign in_ext  = XW'(item_value_i);
  assign out_ext = XW'(rdata);
  assign len_ext = LXW'(count_d);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    idx_d   = idx_q;
    if (cmd_i.load_cmd) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
    if (cmd_i.enq) begin
      count_d = count_q + CW'(1);
    end
    if (cmd_i.deq) begin
      count_d = count_q - CW'(1);
      head_d  = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
    end
    if (cmd_i.del) begin
      count_d = count_q - CW'(1);
      if (count_q == CW'(1)) begin
        head_d = '0;
      end
    end
  end

  assign rd_off = idx_d + CW'(cmd_i.rd_skip);
  assign raddr  = slot(head_q, rd_off);
  assign we     = cmd_i.enq | cmd_i.shift_wr;
  assign waddr  = cmd_i.enq ? slot(head_q, count_q) : slot(head_q, idx_q);
  assign wdata  = cmd_i.enq ? val_q : rdata;

  fqd_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.emit) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cmd) begin
      kind_q <= fqd_kind_e'(kind_i);
      val_q  <= in_ext[VALUE_BITS-1:0];
    end
    if (cmd_i.emit) begin
      ostatus_q <= cmd_i.emit_rej ? STATUS_REJECT : STATUS_OK;
      ovalue_q  <= cmd_i.emit_data ? out_ext[OUT_W-1:0] : '0;
      olen_q    <= len_ext[LEN_W-1:0];
      olast_q   <= cmd_i.emit_last;
    end
  end

  assign sts_o.kind     = kind_q;
  assign sts_o.val_zero = (val_q == '0);
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.full     = (count_q == CW'(DEPTH));
  assign sts_o.hit      = (rdata == val_q);
  assign sts_o.at_last  = ((idx_q + CW'(1)) == count_q);
  assign sts_o.out_free = ~ovalid_q | ~out_stall_i;

  assign out_valid_o  = ovalid_q;
  assign status_o     = ostatus_q;
  assign out_value_o  = ovalue_q;
  assign length_now_o = olen_q;
  assign last_o       = olast_q;

endmodule

// ===== rtl/fifo_queue_with_delete.sv =====
// channel   direction  handshake                 beat fields
// --------  ---------  ------------------------  --------------------------------------
// in        input      in_valid_i / in_stall_o   kind_i, item_value_i
// out       output     out_valid_o / out_stall_i status_o, out_value_o, length_now_o, last_o
//
// one command at a time; enqueue and dequeue go from idle to run and back, the result beat registered
// delete and iterate walk the entries one per cycle (iterate only while the output is free), through
// the single read port of the entry ram
// rst_ni clears head, count and control; entry ram is not cleared and needs no pass
// a stalled output holds the iterate walk in place; the next command is taken once back in idle
module fifo_queue_with_delete import fqd_pkg::*; #(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // command channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [OUT_W-1:0] item_value_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             status_o,
  output logic [OUT_W-1:0] out_value_o,
  output logic [LEN_W-1:0] length_now_o,
  output logic             last_o
);

  // command and status between the sequencer and the queue datapath
  fqd_cmd_t cmd;
  fqd_sts_t sts;

  // sequencer: idle, run (enq/deq/search/iterate), shift (close the gap)
  fqd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // head/count/index registers, entry ram and the output register
  fqd_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_i),
    .item_value_i (item_value_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .out_value_o  (out_value_o),
    .length_now_o (length_now_o),
    .last_o       (last_o)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import fqd_pkg::*;

  localparam int unsigned QDEPTH      = DEPTH_DEF;
  localparam int unsigned HEAD_W      = $clog2(DEPTH_DEF);
  localparam int          RANDOM_CMDS = 456;
  localparam int          PHASE_LEN   = 48;
  localparam int          HOLD_AFTER  = 120;   // result beats before the long hold-off
  localparam int          HOLD_CYCLES = 400;
  localparam int          QUIET_LIMIT = 3000;  // cycles with no beat on either side
  localparam int          TAIL_CYCLES = 64;    // longer than a full delete walk
  localparam int          PRINT_MAX   = 20;

  // one command beat and one result beat
  typedef struct packed {
    fqd_kind_e        kind;
    logic [OUT_W-1:0] value;
  } tag_cmd_t;

  typedef struct packed {
    logic             status;
    logic [OUT_W-1:0] value;
    logic [LEN_W-1:0] length;
    logic             last;
  } tag_reply_t;

  // receiver stall styles, picked at random as the run goes on
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_e;

  // dut signals; the inputs are known from time zero
  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_stall_o;
  logic [1:0]       kind_i       = KIND_ENQ;
  logic [OUT_W-1:0] item_value_i = '0;
  logic             out_valid_o;
  logic             out_stall_i  = 1'b0;
  logic             status_o;
  logic [OUT_W-1:0] out_value_o;
  logic [LEN_W-1:0] length_now_o;
  logic             last_o;

  // commands waiting to be driven, results waiting to arrive
  tag_cmd_t   cmd_backlog[$];
  tag_reply_t tag_replies_due[$];

  // shadow copy of the queue contents
  logic [OUT_W-1:0]  tag_store [QDEPTH];
  logic [HEAD_W-1:0] tag_head  = '0;
  logic [LEN_W-1:0]  tag_count = '0;

  // values reused often so that deletes find their target
  logic [OUT_W-1:0] value_pool [10];

  int       cmds_total   = 0;
  int       cmds_taken   = 0;
  int       beats_seen   = 0;
  int       err_count    = 0;
  logic     cmd_taken    = 1'b0;
  int       burst_left   = 1;
  int       gap_left     = 0;
  int       hold_left    = 0;
  logic     hold_done    = 1'b0;
  int       rx_tick      = 0;
  rx_mode_e rx_mode      = RX_OPEN;
  int       quiet_cycles = 0;

  fifo_queue_with_delete u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .out_value_o  (out_value_o),
    .length_now_o (length_now_o),
    .last_o       (last_o)
  );

  // clock and a single reset at the start
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_MAX) $display("tb_top: beat %0d: %s", beats_seen, msg);
    err_count++;
  endtask

  task automatic queue_cmd(input fqd_kind_e kind, input logic [OUT_W-1:0] value);
    tag_cmd_t c;
    c.kind  = kind;
    c.value = value;
    cmd_backlog.push_back(c);
  endtask

  // store position of the entry at offset off from the head
  function automatic int slot_of(input int off);
    return (int'(tag_head) + off) % QDEPTH;
  endfunction

  // result beat with the length as it stands after the command
  task automatic push_reply(input logic status, input logic [OUT_W-1:0] value,
                            input logic last);
    tag_reply_t r;
    r.status = status;
    r.value  = value;
    r.length = tag_count;
    r.last   = last;
    tag_replies_due.push_back(r);
  endtask

  // update the shadow queue for one accepted command and queue its results
  task automatic apply_tag_command(input fqd_kind_e kind, input logic [OUT_W-1:0] value);
    int hit_at;
    hit_at = -1;
    case (kind)
      KIND_ENQ: begin
        if (value == '0 || tag_count >= QDEPTH) begin
          push_reply(STATUS_REJECT, '0, 1'b1);
        end else begin
          tag_store[slot_of(int'(tag_count))] = value;
          tag_count = tag_count + 1'b1;
          push_reply(STATUS_OK, '0, 1'b1);
        end
      end
      KIND_DEQ: begin
        if (tag_count == '0) begin
          push_reply(STATUS_REJECT, '0, 1'b1);
        end else begin
          value     = tag_store[slot_of(0)];
          tag_head  = HEAD_W'(slot_of(1));
          tag_count = tag_count - 1'b1;
          push_reply(STATUS_OK, value, 1'b1);
        end
      end
      KIND_DEL: begin
        // first match from the head, the rest close up behind it
        if (value != '0) begin
          for (int i = 0; i < int'(tag_count); i++) begin
            if (hit_at < 0 && tag_store[slot_of(i)] == value) hit_at = i;
          end
        end
        if (hit_at < 0) begin
          push_reply(STATUS_REJECT, '0, 1'b1);
        end else begin
          for (int k = hit_at; k + 1 < int'(tag_count); k++) begin
            tag_store[slot_of(k)] = tag_store[slot_of(k + 1)];
          end
          tag_count = tag_count - 1'b1;
          if (tag_count == '0) tag_head = '0;
          push_reply(STATUS_OK, '0, 1'b1);
        end
      end
      default: begin
        // iterate: one beat per entry, or a single empty marker beat
        if (tag_count == '0) begin
          push_reply(STATUS_OK, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(tag_count); i++) begin
            push_reply(STATUS_OK, tag_store[slot_of(i)], i + 1 == int'(tag_count));
          end
        end
      end
    endcase
  endtask

  // command driver: bursts of random length, random gaps between them
  always @(negedge clk_i) begin
    tag_cmd_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !cmd_taken) begin
      // stalled beat holds still
    end else if (gap_left != 0) begin
      in_valid_i <= 1'b0;
      gap_left   <= gap_left - 1;
    end else if (cmd_backlog.size() != 0) begin
      nxt = cmd_backlog.pop_front();
      kind_i       <= nxt.kind;
      item_value_i <= nxt.value;
      in_valid_i   <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 16);
        // a third of the bursts run straight into the next one
        if ($urandom_range(0, 2) == 0) gap_left <= 0;
        else gap_left <= $urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // result receiver: its own stall pattern plus one long hold-off
  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && beats_seen >= HOLD_AFTER) begin
      // block fills up and has to stall its command side
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      case (rx_mode)
        RX_OPEN:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:  out_stall_i <= rx_tick[0];
      endcase
    end
  end

  // monitor: predict on command beats, check result beats
  always @(posedge clk_i) begin
    tag_reply_t want;
    cmd_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        apply_tag_command(fqd_kind_e'(kind_i), item_value_i);
        cmds_taken <= cmds_taken + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (tag_replies_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat, value %h", out_value_o));
        end else begin
          want = tag_replies_due.pop_front();
          if (status_o !== want.status)
            report_mismatch($sformatf("status got %b want %b", status_o, want.status));
          if (out_value_o !== want.value)
            report_mismatch($sformatf("out_value got %h want %h", out_value_o, want.value));
          if (length_now_o !== want.length)
            report_mismatch($sformatf("length_now got %0d want %0d",
                                      length_now_o, want.length));
          if (last_o !== want.last)
            report_mismatch($sformatf("last got %b want %b", last_o, want.last));
        end
        beats_seen <= beats_seen + 1;
      end
    end
  end

  // watchdog on cycles with no beat either way
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic             filling;
    fqd_kind_e        kind;
    logic [OUT_W-1:0] value;
    int               roll;
    int               vroll;

    filling = 1'b0;
    value_pool[0] = 32'h0000_0001;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h0000_0002;
    for (int i = 4; i < 10; i++) value_pool[i] = $urandom() | 32'h1;

    // directed: empty queue cases, zero values, extremes, duplicates
    queue_cmd(KIND_ITER, 32'h0);
    queue_cmd(KIND_DEQ,  32'hFFFF_FFFF);
    queue_cmd(KIND_DEL,  32'h0000_0005);
    queue_cmd(KIND_ENQ,  32'h0);
    queue_cmd(KIND_DEL,  32'h0);
    queue_cmd(KIND_ENQ,  32'hFFFF_FFFF);
    queue_cmd(KIND_ENQ,  32'h0000_0001);
    queue_cmd(KIND_ENQ,  32'h8000_0000);
    queue_cmd(KIND_ENQ,  32'h0000_0001);
    queue_cmd(KIND_ENQ,  32'h7FFF_FFFF);
    queue_cmd(KIND_ITER, 32'h0);
    queue_cmd(KIND_DEL,  32'h0000_0001);  // first of two equal entries
    queue_cmd(KIND_ITER, 32'h0);
    queue_cmd(KIND_DEL,  32'h1234_5678);  // not held
    queue_cmd(KIND_DEL,  32'h7FFF_FFFF);  // tail entry
    queue_cmd(KIND_DEQ,  32'h0);
    queue_cmd(KIND_ITER, 32'h0);
    queue_cmd(KIND_DEQ,  32'h0);
    queue_cmd(KIND_DEQ,  32'h0);
    queue_cmd(KIND_DEQ,  32'h0);          // already empty, rejected
    queue_cmd(KIND_ENQ,  32'hAAAA_AAAA);
    queue_cmd(KIND_DEL,  32'hAAAA_AAAA);  // delete down to empty
    queue_cmd(KIND_ITER, 32'h0);

    // random: fill phases lean on enqueue, drain phases on dequeue and delete
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n % PHASE_LEN == 0) filling = !filling;
      roll = $urandom_range(0, 99);
      if (filling)
        kind = (roll < 78) ? KIND_ENQ : (roll < 86) ? KIND_DEL :
               (roll < 92) ? KIND_DEQ : KIND_ITER;
      else
        kind = (roll < 30) ? KIND_ENQ : (roll < 60) ? KIND_DEQ :
               (roll < 88) ? KIND_DEL : KIND_ITER;
      vroll = $urandom_range(0, 99);
      value = $urandom();
      if (kind == KIND_ENQ) begin
        if (vroll < 4) value = '0;
        else if (vroll >= 30) value = value_pool[$urandom_range(0, 9)];
      end else if (kind == KIND_DEL) begin
        if (vroll < 5) value = '0;
        else if (vroll >= 12) value = value_pool[$urandom_range(0, 9)];
      end
      queue_cmd(kind, value);
    end
    cmds_total = cmd_backlog.size();

    while (cmds_taken < cmds_total) @(posedge clk_i);
    while (tag_replies_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
